// ===== hdl/battery_percent_estimator_core_defines.svh =====
// Assertion macros used by the battery percent estimator checker.
`ifndef BATTERY_PERCENT_ESTIMATOR_CORE_DEFINES_SVH
`define BATTERY_PERCENT_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define BPE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bpe same-cycle check failed");

// Next-cycle implication, held off during reset
`define BPE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bpe next-cycle check failed");

`endif

// ===== hdl/bpe_pkg.sv =====
// Shared widths, register indexes and lookup tables of the battery percent estimator.
package bpe_pkg;

    localparam int ADC_W     = 12;
    localparam int RATIO_W   = 12;
    localparam int PCT_W     = 7;
    localparam int MV_W      = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 12;
    localparam int PROD_W    = ADC_W + RATIO_W;
    localparam int SCALE_SH  = 8;
    localparam int NUM_KNOTS = 7;
    localparam int SEG_W     = 3;
    localparam int DV_W      = 9;
    localparam int REM_W     = 13;
    localparam int QUO_W     = 5;
    localparam int CNT_W     = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_RATIO   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_STEP = 1'b1;

    localparam logic [RATIO_W-1:0] DIVIDER_RATIO_RST   = 12'd512;
    localparam logic [PCT_W-1:0]   HYSTERESIS_STEP_RST = 7'd5;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Knots of the discharge curve: millivolts and percent
    localparam logic [MV_W-1:0] KNOT_MV [NUM_KNOTS] =
        '{16'd3000, 16'd3300, 16'd3500, 16'd3700, 16'd3900, 16'd4100, 16'd4200};
    localparam logic [PCT_W-1:0] KNOT_PC [NUM_KNOTS] =
        '{7'd0, 7'd10, 7'd25, 7'd50, 7'd75, 7'd90, 7'd100};

    // Voltage span of a segment
    function automatic logic [DV_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
        logic [MV_W-1:0] d;
        d = KNOT_MV[seg + 3'd1] - KNOT_MV[seg];
        return d[DV_W-1:0];
    endfunction

    // Percent rise over a segment
    function automatic logic [PCT_W-1:0] seg_rise(input logic [SEG_W-1:0] seg);
        return KNOT_PC[seg + 3'd1] - KNOT_PC[seg];
    endfunction

endpackage

// ===== hdl/bpe_sample_if.sv =====
// Request channel that carries one ADC reading.
interface bpe_sample_if;
    import bpe_pkg::*;

    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_millivolts;

    modport source (output valid, output adc_millivolts, input ready);
    modport sink   (input valid, input adc_millivolts, output ready);
endinterface

// ===== hdl/bpe_result_if.sv =====
// Request channel that carries one charge estimate.
interface bpe_result_if;
    import bpe_pkg::*;

    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] held_percent_out;
    logic [PCT_W-1:0] interp_percent;
    logic [MV_W-1:0]  battery_millivolts;

    modport source (output valid, output held_percent_out, output interp_percent,
                    output battery_millivolts, input ready);
    modport sink   (input valid, input held_percent_out, input interp_percent,
                    input battery_millivolts, output ready);
endinterface

// ===== hdl/battery_percent_estimator_core.sv =====
// Battery state of charge estimator: divider scaling, curve lookup and hysteresis.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------------
//  sample   | in  | valid/ready   | adc_millivolts
//  result   | out | valid/ready   | held_percent_out, interp_percent, battery_millivolts
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// A request inside the curve goes from acceptance to its result through scaling on the
// shared multiplier, the segment search, the slope on the multiplier, five restoring
// division steps on the subtractor, and the commit.
// Readings clamped to 0 or 100 percent skip the slope and division.
// The next reading is taken in the cycle after the commit.
// Reset clears the sequencer, the held percentage and the registers to their defaults.
// The result register holds a request until taken; a new reading is accepted meanwhile,
// and only the commit waits on a full result register.
module battery_percent_estimator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpe_pkg::CFG_W-1:0]      cfg_data,
    bpe_sample_if.sink                     sample,
    bpe_result_if.source                   result
);
    import bpe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SCALE,
        ST_SEG_FIND,
        ST_MUL_SLOPE,
        ST_DIV_STEP,
        ST_COMMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [RATIO_W-1:0]  ratio_reg, ratio_next;
    logic [PCT_W-1:0]    step_reg, step_next;
    logic                have_reg, have_next;
    logic [PCT_W-1:0]    held_reg, held_next;
    logic [ADC_W-1:0]    adc_reg, adc_next;
    logic [MV_W-1:0]     bat_reg, bat_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic [DV_W-1:0]     dv_reg, dv_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PCT_W-1:0]    raw_reg, raw_next;
    logic                out_valid_reg, out_valid_next;
    logic [PCT_W-1:0]    out_held_reg, out_held_next;
    logic [PCT_W-1:0]    out_raw_reg, out_raw_next;
    logic [MV_W-1:0]     out_bat_reg, out_bat_next;

    logic [RATIO_W-1:0]  mul_a;
    logic [RATIO_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;
    logic [SEG_W-1:0]    seg_find;
    logic [MV_W-1:0]     dv_wide;
    logic [REM_W-1:0]    span_sh;
    logic                div_ge;
    logic [QUO_W-1:0]    quo_upd;
    logic [PCT_W-1:0]    diff;
    logic                commit_ok;

    // Select operands of the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_MUL_SLOPE:
            begin
                mul_a = RATIO_W'(dv_reg);
                mul_b = RATIO_W'(seg_rise(seg_reg));
            end
            default:
            begin
                mul_a = adc_reg;
                mul_b = ratio_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Locate the segment: count interior knots at or below the voltage
    always_comb
    begin
        seg_find = '0;
        for (int k = 1; k < NUM_KNOTS - 1; k++)
        begin
            if (bat_reg >= KNOT_MV[k])
            begin
                seg_find = seg_find + 3'd1;
            end
        end
    end

    assign dv_wide = bat_reg - KNOT_MV[seg_find];

    // One restoring division step on the subtractor
    assign span_sh = REM_W'(seg_span(seg_reg)) << cnt_reg;
    assign div_ge  = (rem_reg >= span_sh);
    assign quo_upd = quo_reg | (QUO_W'(div_ge) << cnt_reg);

    assign diff      = (raw_reg >= held_reg) ? (raw_reg - held_reg) : (held_reg - raw_reg);
    assign commit_ok = !out_valid_reg || result.ready;

    // Sequence one request
    always_comb
    begin
        state_next     = state_reg;
        ratio_next     = ratio_reg;
        step_next      = step_reg;
        have_next      = have_reg;
        held_next      = held_reg;
        adc_next       = adc_reg;
        bat_next       = bat_reg;
        seg_next       = seg_reg;
        dv_next        = dv_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        raw_next       = raw_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_held_next  = out_held_reg;
        out_raw_next   = out_raw_reg;
        out_bat_next   = out_bat_reg;

        // Take register writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIVIDER_RATIO:   ratio_next = cfg_data[RATIO_W-1:0];
                CFG_HYSTERESIS_STEP: step_next  = cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    adc_next   = sample.adc_millivolts;
                    state_next = ST_MUL_SCALE;
                end
            end
            ST_MUL_SCALE:
            begin
                // A 24-bit product shifted by 8 always fits 16 bits, so no clamp is needed
                bat_next   = prod[PROD_W-1:SCALE_SH];
                state_next = ST_SEG_FIND;
            end
            ST_SEG_FIND:
            begin
                if (bat_reg <= KNOT_MV[0])
                begin
                    raw_next   = '0;
                    state_next = ST_COMMIT;
                end
                else if (bat_reg >= KNOT_MV[NUM_KNOTS-1])
                begin
                    raw_next   = PCT_FULL;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    seg_next   = seg_find;
                    dv_next    = dv_wide[DV_W-1:0];
                    state_next = ST_MUL_SLOPE;
                end
            end
            ST_MUL_SLOPE:
            begin
                rem_next   = prod[REM_W-1:0];
                quo_next   = '0;
                cnt_next   = CNT_W'(QUO_W - 1);
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - span_sh;
                end
                quo_next = quo_upd;
                if (cnt_reg == '0)
                begin
                    raw_next   = KNOT_PC[seg_reg] + PCT_W'(quo_upd);
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            ST_COMMIT:
            begin
                // Hold until the result register is free
                if (commit_ok)
                begin
                    if (!have_reg || diff >= step_reg)
                    begin
                        held_next     = raw_reg;
                        out_held_next = raw_reg;
                    end
                    else
                    begin
                        out_held_next = held_reg;
                    end
                    have_next      = 1'b1;
                    out_raw_next   = raw_reg;
                    out_bat_next   = bat_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, registers and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ratio_reg     <= DIVIDER_RATIO_RST;
            step_reg      <= HYSTERESIS_STEP_RST;
            have_reg      <= 1'b0;
            held_reg      <= '0;
            adc_reg       <= '0;
            bat_reg       <= '0;
            seg_reg       <= '0;
            dv_reg        <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            raw_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_held_reg  <= '0;
            out_raw_reg   <= '0;
            out_bat_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ratio_reg     <= ratio_next;
            step_reg      <= step_next;
            have_reg      <= have_next;
            held_reg      <= held_next;
            adc_reg       <= adc_next;
            bat_reg       <= bat_next;
            seg_reg       <= seg_next;
            dv_reg        <= dv_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            raw_reg       <= raw_next;
            out_valid_reg <= out_valid_next;
            out_held_reg  <= out_held_next;
            out_raw_reg   <= out_raw_next;
            out_bat_reg   <= out_bat_next;
        end
    end

    assign sample.ready              = (state_reg == ST_IDLE);
    assign result.valid              = out_valid_reg;
    assign result.held_percent_out   = out_held_reg;
    assign result.interp_percent     = out_raw_reg;
    assign result.battery_millivolts = out_bat_reg;

endmodule

// ===== hdl/bpe_checker.sv =====
// Port-level checks of the battery percent estimator and their binding.
`include "battery_percent_estimator_core_defines.svh"

module bpe_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     sample_valid,
    input logic                     sample_ready,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic [bpe_pkg::PCT_W-1:0] held_percent_out,
    input logic [bpe_pkg::PCT_W-1:0] interp_percent,
    input logic [bpe_pkg::MV_W-1:0]  battery_millivolts
);
    import bpe_pkg::*;

    logic                          result_stall;
    logic [PCT_W+PCT_W+MV_W-1:0]   result_payload;
    logic                          at_empty;
    logic                          at_full;

    assign result_stall   = result_valid && !result_ready;
    assign result_payload = {held_percent_out, interp_percent, battery_millivolts};
    assign at_empty       = result_valid && (battery_millivolts <= KNOT_MV[0]);
    assign at_full        = result_valid && (battery_millivolts >= KNOT_MV[NUM_KNOTS-1]);

    // An accepted reading keeps the block busy in the next cycle
    `BPE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, sample_valid && sample_ready, !sample_ready)

    // A stalled result holds its payload
    `BPE_ASSERT_NXT(a_result_hold, clk, rst_n, result_stall, result_valid && $stable(result_payload))

    // Percentages stay within the full scale
    `BPE_ASSERT_IMP(a_pct_range, clk, rst_n, result_valid, interp_percent <= PCT_FULL && held_percent_out <= PCT_FULL)

    // An empty battery reads zero, a full one reads full scale
    `BPE_ASSERT_IMP(a_clamp_low, clk, rst_n, at_empty, interp_percent == '0)
    `BPE_ASSERT_IMP(a_clamp_high, clk, rst_n, at_full, interp_percent == PCT_FULL)

endmodule

bind battery_percent_estimator_core bpe_checker u_bpe_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .sample_valid       (sample.valid),
    .sample_ready       (sample.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .held_percent_out   (result.held_percent_out),
    .interp_percent     (result.interp_percent),
    .battery_millivolts (result.battery_millivolts)
);

// ===== bench/tb_battery_percent_estimator_core.sv =====
// Testbench for the battery percent estimator: divider scaling, curve lookup and hysteresis.
module tb_battery_percent_estimator_core;
    import bpe_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 4000;
    localparam int NUM_SETTINGS  = 9;
    localparam int PHASE_ITEMS   = 126;
    localparam int PICK_RANDOM   = -1;
    localparam int NUM_EDGE      = 18;

    // Curve edges, knots and their neighbors, alternating bit patterns (at reset ratio 2.0)
    localparam logic [ADC_W-1:0] EDGE_READINGS [NUM_EDGE] = '{
        12'd1520, 12'd0,    12'd4095, 12'd1500, 12'd1501, 12'd1650,
        12'd1651, 12'd1749, 12'd1750, 12'd1850, 12'd1950, 12'd2050,
        12'd2099, 12'd2100, 12'd2730, 12'd1365, 12'd1800, 12'd1700};

    // Register settings per phase: extremes first, then random ones, then back to defaults
    localparam int SET_RATIO [NUM_SETTINGS] =
        '{256, 4095, 0, 255, 1, 640, PICK_RANDOM, PICK_RANDOM, 512};
    localparam int SET_STEP [NUM_SETTINGS] =
        '{0, 100, 127, 1, 3, 101, PICK_RANDOM, PICK_RANDOM, 5};

    typedef struct packed {
        logic [PCT_W-1:0] held;
        logic [PCT_W-1:0] raw;
        logic [MV_W-1:0]  mv;
    } estimate_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_BURSTY} rx_mode_t;

    // Predicts each charge estimate and checks results in order
    class charge_estimate_board;
        logic [RATIO_W-1:0] ratio;
        logic [PCT_W-1:0]   step;
        bit                 have_reading;
        logic [PCT_W-1:0]   held;
        estimate_t          pending[$];
        int unsigned        knee_mv [7];
        int unsigned        knee_pc [7];
        int                 mismatches;
        int                 checked;
        int                 empty_hits;
        int                 full_hits;
        int                 curve_hits;
        int                 held_moves;

        function new();
            knee_mv      = '{3000, 3300, 3500, 3700, 3900, 4100, 4200};
            knee_pc      = '{0, 10, 25, 50, 75, 90, 100};
            ratio        = DIVIDER_RATIO_RST;
            step         = HYSTERESIS_STEP_RST;
            have_reading = 1'b0;
            held         = '0;
            mismatches   = 0;
            checked      = 0;
            empty_hits   = 0;
            full_hits    = 0;
            curve_hits   = 0;
            held_moves   = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_DIVIDER_RATIO)
                ratio = data[RATIO_W-1:0];
            else if (idx == CFG_HYSTERESIS_STEP)
                step = data[PCT_W-1:0];
        endfunction

        // Scale pin voltage by the Q4.8 divider gain, saturating at the 16-bit top
        function logic [MV_W-1:0] battery_mv(logic [ADC_W-1:0] adc);
            logic [ADC_W+RATIO_W-1:0] prod;
            prod = adc * ratio;
            prod = prod >> 8;
            return (prod > 24'd65535) ? 16'hFFFF : prod[MV_W-1:0];
        endfunction

        // Interpolate over the discharge curve, truncating
        function logic [PCT_W-1:0] curve_percent(logic [MV_W-1:0] mv);
            int unsigned v;
            int unsigned seg;
            v = mv;
            if (v <= knee_mv[0])
                return '0;
            if (v >= knee_mv[6])
                return 7'd100;
            seg = 0;
            while (v >= knee_mv[seg+1])
                seg++;
            return PCT_W'(knee_pc[seg] + (v - knee_mv[seg]) * (knee_pc[seg+1] - knee_pc[seg])
                          / (knee_mv[seg+1] - knee_mv[seg]));
        endfunction

        // Work out the estimate for an accepted reading and queue it
        function void note_request(logic [ADC_W-1:0] adc);
            estimate_t        e;
            logic [PCT_W-1:0] gap;
            e.mv  = battery_mv(adc);
            e.raw = curve_percent(e.mv);
            gap   = (e.raw >= held) ? e.raw - held : held - e.raw;
            if (!have_reading || gap >= step)
            begin
                if (have_reading && e.raw != held)
                    held_moves++;
                held         = e.raw;
                have_reading = 1'b1;
            end
            e.held = held;
            if (e.raw == 0)
                empty_hits++;
            else if (e.raw == 100)
                full_hits++;
            else
                curve_hits++;
            pending.push_back(e);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH %s", $time, what);
            mismatches++;
        endtask

        // Compare one result with the oldest outstanding estimate
        task check_result(logic [PCT_W-1:0] held_got, logic [PCT_W-1:0] raw_got,
                          logic [MV_W-1:0] mv_got);
            estimate_t e;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing outstanding: held=%0d raw=%0d mv=%0d",
                                          held_got, raw_got, mv_got));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (held_got !== e.held)
                report_mismatch($sformatf("held_percent_out got %0d want %0d (mv=%0d)",
                                          held_got, e.held, e.mv));
            if (raw_got !== e.raw)
                report_mismatch($sformatf("interp_percent got %0d want %0d (mv=%0d)",
                                          raw_got, e.raw, e.mv));
            if (mv_got !== e.mv)
                report_mismatch($sformatf("battery_millivolts got %0d want %0d", mv_got, e.mv));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    rx_mode_t             rx_mode;
    int                   rx_tick;
    int                   quiet_cycles;
    charge_estimate_board sb;

    bpe_sample_if sample_ch ();
    bpe_result_if result_ch ();

    battery_percent_estimator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    initial clk = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Note accepted readings and check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.held_percent_out, result_ch.interp_percent,
                                result_ch.battery_millivolts);
            if (sample_ch.valid && sample_ch.ready)
                sb.note_request(sample_ch.adc_millivolts);
        end
    end

    // Stall the result side on a random pattern that is picked anew whenever rx_tick wraps
    always @(negedge clk)
    begin
        if (rx_tick == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:      result_ch.ready = 1'b1;
            RX_COIN:        result_ch.ready = 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: result_ch.ready = (rx_tick % 4 == 0);
            default:        result_ch.ready = (rx_tick % 16 < 10);
        endcase
        rx_tick = (rx_tick + 1) % 48;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout after %0d quiet cycles", quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Present one reading and hold it until taken
    task automatic send_reading(logic [ADC_W-1:0] adc);
        @(negedge clk);
        sample_ch.valid          = 1'b1;
        sample_ch.adc_millivolts = adc;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Drop valid for a number of cycles, with junk on the data
    task automatic pause_sender(int cycles);
        @(negedge clk);
        sample_ch.valid          = 1'b0;
        sample_ch.adc_millivolts = ADC_W'($urandom_range(0, 4095));
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Hold off until every outstanding estimate has come back, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.apply_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mostly aim the scaled voltage at the curve or its knots; sometimes any reading
    function automatic logic [ADC_W-1:0] pick_adc();
        int unsigned pick;
        int unsigned target;
        int unsigned adc;
        pick = $urandom_range(0, 9);
        if (pick == 0 || sb.ratio == 0)
            return ADC_W'($urandom_range(0, 4095));
        if (pick <= 2)
            target = sb.knee_mv[$urandom_range(0, 6)] + $urandom_range(0, 4) - 2;
        else
            target = $urandom_range(2900, 4300);
        adc = (target * 256 + sb.ratio - 1) / sb.ratio;
        if ($urandom_range(0, 1))
            adc = adc + $urandom_range(0, 2);
        if (adc > 4095)
            adc = 4095;
        return adc[ADC_W-1:0];
    endfunction

    // Send random readings in bursts, with or without gaps between them
    task automatic run_phase(int count, bit gaps_on);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    send_reading(pick_adc());
                    sent++;
                end
            end
            if (gaps_on && $urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
            else if ($urandom_range(0, 39) == 0)
                drain();
        end
    endtask

    initial
    begin
        logic [RATIO_W-1:0] ratio_val;
        logic [PCT_W-1:0]   step_val;
        sb                       = new();
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.adc_millivolts = '0;
        result_ch.ready          = 1'b0;
        rx_mode                  = RX_ALWAYS;
        rx_tick                  = 0;
        quiet_cycles             = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Edge readings under the reset register values
        foreach (EDGE_READINGS[i])
            send_reading(EDGE_READINGS[i]);

        // Step through the register settings, idle between each
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            drain();
            if (SET_RATIO[p] == PICK_RANDOM)
                ratio_val = (p % 2) ? RATIO_W'($urandom_range(0, 4095))
                                    : RATIO_W'($urandom_range(256, 4095));
            else
                ratio_val = RATIO_W'(SET_RATIO[p]);
            if (SET_STEP[p] == PICK_RANDOM)
                step_val = (p % 2) ? PCT_W'($urandom_range(0, 127))
                                   : PCT_W'($urandom_range(0, 20));
            else
                step_val = PCT_W'(SET_STEP[p]);
            write_reg(CFG_DIVIDER_RATIO, ratio_val);
            write_reg(CFG_HYSTERESIS_STEP, {5'($urandom_range(0, 31)), step_val});
            run_phase(PHASE_ITEMS, (p % 3) != 2);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d estimates never came back", sb.pending.size()));

        $display("Checked %0d estimates over %0d register settings plus reset values",
                 sb.checked, NUM_SETTINGS);
        $display("Raw percent: %0d empty, %0d full, %0d on the curve; held value moved %0d times",
                 sb.empty_hits, sb.full_hits, sb.curve_hits, sb.held_moves);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
